[src/assert_macros.svh]
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property that must hold in the same cycle
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// property that must hold in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_NOW(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[src/ffua_pkg.sv]
// shared types and constants of the first-fit unit allocator
`default_nettype none

package ffua_pkg;

  localparam int SIZE_W     = 11;  // size field
  localparam int UNITS_W    = 11;  // mem_units register
  localparam int START_W    = 10;  // start_address field
  localparam int FREED_W    = 11;  // freed_units field

  localparam logic [UNITS_W-1:0] UNITS_RESET = 11'd1024;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef struct packed {
    logic               alloc_failed;
    logic [START_W-1:0] start_address;
    logic [FREED_W-1:0] freed_units;
  } result_t;

endpackage

`default_nettype wire

[src/ffua_owner_mem.sv]
// owner tag store, one write port and one registered read port
`default_nettype none

module ffua_owner_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[src/ffua_seq.sv]
// request sequencer: clearing pass, first-fit scan, fill and owner free sweep
`default_nettype none
`include "assert_macros.svh"

module ffua_seq #(
  parameter int MAX_UNITS  = 1024,
  parameter int OWNER_BITS = 10,
  parameter int AW         = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ffua_pkg::UNITS_W-1:0]   cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_req,
  input  wire logic [ffua_pkg::SIZE_W-1:0]    in_size,
  input  wire logic [OWNER_BITS-1:0]          in_owner,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output ffua_pkg::result_t                   res,
  output logic                                mem_we,
  output logic [AW-1:0]                       mem_wr_addr,
  output logic [OWNER_BITS-1:0]               mem_wr_data,
  output logic                                mem_rd_en,
  output logic [AW-1:0]                       mem_rd_addr,
  input  wire logic [OWNER_BITS-1:0]          mem_rd_data
);

  localparam int CW = $clog2(MAX_UNITS + 1);
  localparam int WW = ((CW > ffua_pkg::SIZE_W) ? CW : ffua_pkg::SIZE_W) + 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ALLOC, S_FILL, S_FREE, S_DONE
  } state_t;

  state_t                         state;
  logic [ffua_pkg::UNITS_W-1:0]   mem_units;
  logic [CW-1:0]                  idx;
  logic                           chk_valid;
  logic [AW-1:0]                  chk_idx;
  logic [WW-1:0]                  run;
  logic [WW-1:0]                  size_r;
  logic [OWNER_BITS-1:0]          owner_r;
  logic [WW-1:0]                  limit;
  logic [AW-1:0]                  fill_addr;
  logic [WW-1:0]                  fill_cnt;
  logic [CW-1:0]                  freed;
  logic                           res_failed;
  logic [AW-1:0]                  res_start;

  logic [WW-1:0] limit_now;
  logic [WW-1:0] in_size_w;
  logic [WW-1:0] idx_w;
  logic          alloc_issue;
  logic          free_issue;
  logic          unit_free;
  logic          fit;
  logic [WW-1:0] fit_start;
  logic          alloc_go;

  // units in use, clamped to the store depth
  assign limit_now = (WW'(mem_units) > WW'(MAX_UNITS)) ? WW'(MAX_UNITS) : WW'(mem_units);
  assign in_size_w = WW'(in_size);
  assign idx_w     = WW'(idx);

  // feasible allocate word taken while idle
  assign alloc_go = (state == S_IDLE) && in_valid && (in_req == ffua_pkg::REQ_ALLOC) &&
                    (in_owner != '0) && (in_size_w <= limit_now);

  assign alloc_issue = (state == S_ALLOC) && (idx_w < limit);
  assign free_issue  = (state == S_FREE) && (idx < CW'(MAX_UNITS));
  assign unit_free   = chk_valid && (mem_rd_data == '0);
  assign fit         = unit_free && ((size_r == '0) || ((run + WW'(1)) == size_r));
  assign fit_start   = (size_r == '0) ? WW'(chk_idx) : (WW'(chk_idx) + WW'(1) - size_r);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res.alloc_failed  = res_failed;
  assign res.start_address = ffua_pkg::START_W'(res_start);
  assign res.freed_units   = ffua_pkg::FREED_W'(freed);

  always_comb begin
    mem_we      = 1'b0;
    mem_wr_addr = idx[AW-1:0];
    mem_wr_data = '0;
    mem_rd_en   = alloc_issue || free_issue;
    mem_rd_addr = idx[AW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_FILL: begin
        mem_we      = 1'b1;
        mem_wr_addr = fill_addr;
        mem_wr_data = owner_r;
      end
      S_FREE: begin
        mem_we      = chk_valid && (mem_rd_data == owner_r);
        mem_wr_addr = chk_idx;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      chk_valid <= 1'b0;
      mem_units <= ffua_pkg::UNITS_RESET;
    end else begin
      if (cfg_wr_en) begin
        mem_units <= cfg_wr_data;
      end
      case (state)
        S_CLEAR: begin
          if (idx == CW'(MAX_UNITS - 1)) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            size_r     <= in_size_w;
            owner_r    <= in_owner;
            limit      <= limit_now;
            idx        <= '0;
            chk_valid  <= 1'b0;
            run        <= '0;
            freed      <= '0;
            res_start  <= '0;
            if (in_req == ffua_pkg::REQ_FREE) begin
              res_failed <= 1'b0;
              state      <= (in_owner == '0) ? S_DONE : S_FREE;
            end else if ((in_owner == '0) || (in_size_w > limit_now)) begin
              res_failed <= 1'b1;
              state      <= S_DONE;
            end else begin
              res_failed <= 1'b0;
              state      <= S_ALLOC;
            end
          end
        end
        S_ALLOC: begin
          chk_valid <= alloc_issue;
          chk_idx   <= idx[AW-1:0];
          if (alloc_issue) begin
            idx <= idx + CW'(1);
          end
          if (fit) begin
            res_start <= AW'(fit_start);
            fill_addr <= AW'(fit_start);
            fill_cnt  <= size_r;
            state     <= (size_r == '0) ? S_DONE : S_FILL;
          end else if (chk_valid) begin
            run <= unit_free ? (run + WW'(1)) : '0;
          end else if (idx_w >= limit) begin
            res_failed <= 1'b1;
            state      <= S_DONE;
          end
        end
        S_FILL: begin
          fill_addr <= fill_addr + AW'(1);
          fill_cnt  <= fill_cnt - WW'(1);
          if (fill_cnt == WW'(1)) begin
            state <= S_DONE;
          end
        end
        S_FREE: begin
          chk_valid <= free_issue;
          chk_idx   <= idx[AW-1:0];
          if (free_issue) begin
            idx <= idx + CW'(1);
          end
          if (mem_we) begin
            freed <= freed + CW'(1);
          end
          if (!chk_valid && !free_issue) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the fill never writes past the units in use
  `ASSERT_NOW(a_fill_in_range, clk, rst, state == S_FILL, WW'(fill_addr) < limit)
  // a feasible allocate always goes on to the scan
  `ASSERT_NEXT(a_alloc_scans, clk, rst, alloc_go, state == S_ALLOC)
  // the free count never runs ahead of the units read
  `ASSERT_NOW(a_freed_bound, clk, rst, state == S_FREE, freed <= idx)

endmodule

`default_nettype wire

[src/ffua_out_reg.sv]
// result output register between the sequencer and the master side
`default_nettype none

module ffua_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire ffua_pkg::result_t in_res,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output ffua_pkg::result_t      out_res
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_res <= in_res;
    end
  end

endmodule

`default_nettype wire

[src/first_fit_unit_allocator.sv]
// top level of the first-fit unit allocator
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tuser: req_type; tdata: size, owner_id
//  m_*      out  m_tvalid/m_tready    tuser: alloc_failed; tdata: start_address, freed_units
//  cfg_*    in   cfg_wr_en            cfg_wr_data: mem_units
//
// after reset a clearing pass writes every owner tag to free, with s_tready low;
// cfg writes are taken during that pass
// allocate: one tag read per cycle over the units in use, then one write per
// cycle for the size units tagged
// free: one read per cycle over all MAX_UNITS tags, matching tags cleared in
// flight; owner zero and infeasible allocates skip the scan and go straight to the result
// the tag store with one read and one write port paces every word; s_tready is
// high only idle
// a finished result waits in the output register, so the next word is accepted
// while m_tready is low; the sequencer stalls only if a second result is ready
`default_nettype none

module first_fit_unit_allocator #(
  parameter int MAX_UNITS  = 1024,
  parameter int OWNER_BITS = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration
  input  wire logic                                 cfg_wr_en,
  input  wire logic [ffua_pkg::UNITS_W-1:0]         cfg_wr_data,   // mem_units
  // request stream
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [((ffua_pkg::SIZE_W+OWNER_BITS+7)/8)*8-1:0] s_tdata, // size, owner_id
  input  wire logic                                 s_tuser,       // req_type
  // result stream
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  output logic [((ffua_pkg::START_W+ffua_pkg::FREED_W+7)/8)*8-1:0] m_tdata, // start_address, freed_units
  output logic                                      m_tuser        // alloc_failed
);

  localparam int AW     = $clog2(MAX_UNITS);
  localparam int OUT_W  = ffua_pkg::START_W + ffua_pkg::FREED_W;
  localparam int M_PAD  = ((OUT_W + 7) / 8) * 8 - OUT_W;

  // sequencer to output register
  logic              res_valid;
  logic              res_ready;
  ffua_pkg::result_t res;
  ffua_pkg::result_t out_res;

  // tag store port
  logic                  mem_we;
  logic [AW-1:0]         mem_wr_addr;
  logic [OWNER_BITS-1:0] mem_wr_data;
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  logic [OWNER_BITS-1:0] mem_rd_data;

  // unpack the request word
  logic [ffua_pkg::SIZE_W-1:0] req_size;
  logic [OWNER_BITS-1:0]       req_owner;

  assign req_size  = s_tdata[ffua_pkg::SIZE_W-1:0];
  assign req_owner = s_tdata[ffua_pkg::SIZE_W +: OWNER_BITS];

  ffua_seq #(
    .MAX_UNITS  (MAX_UNITS),
    .OWNER_BITS (OWNER_BITS),
    .AW         (AW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_req      (s_tuser),
    .in_size     (req_size),
    .in_owner    (req_owner),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ffua_owner_mem #(
    .DEPTH (MAX_UNITS),
    .AW    (AW),
    .DW    (OWNER_BITS)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  ffua_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_ready  (res_ready),
    .in_res    (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  // pack the result word, start address in the low bits
  assign m_tdata = {{M_PAD{1'b0}}, out_res.freed_units, out_res.start_address};
  assign m_tuser = out_res.alloc_failed;

endmodule

`default_nettype wire
